FILE: rtl/frq_pkg.sv
// frq_pkg: shared types and constants of the flagged request queue
// operation and status codes, entry type codes, cell command struct
// no dependencies
`default_nettype none

package frq_pkg;

    localparam int DEF_QUEUE_DEPTH = 16;
    localparam int DEF_HANDLE_BITS = 16;

    localparam int KIND_BITS       = 3;
    localparam int IO_HANDLE_BITS  = 16;
    localparam int TYPE_BITS       = 2;
    localparam int STATUS_BITS     = 2;

    localparam logic [TYPE_BITS-1:0] TYPE_REQ      = 2'd0;
    localparam logic [TYPE_BITS-1:0] TYPE_RSP_DATA = 2'd1;

    typedef enum logic [KIND_BITS-1:0] {
        K_ENQUEUE     = 3'd0,
        K_DEQUEUE     = 3'd1,
        K_PEEK_HEAD   = 3'd2,
        K_PEEK_SENT   = 3'd3,
        K_REMOVE_SENT = 3'd4,
        K_REMOVE_DATA = 3'd5,
        K_PEEK_UNSENT = 3'd6,
        K_CLEAR       = 3'd7
    } t_kind;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK   = 2'd0,
        ST_NONE = 2'd1,
        ST_FULL = 2'd2,
        ST_NULL = 2'd3
    } t_status;

    typedef struct packed {
        logic                 capture;
        logic                 match_any;
        logic                 sent;
        logic [TYPE_BITS-1:0] typ;
        logic                 enq;
    } t_cell_cmd;

endpackage

`default_nettype wire

FILE: rtl/frq_req_if.sv
// frq_req_if: request channel of the flagged request queue
// valid/ready handshake with operation kind and entry payload
// depends on frq_pkg
`default_nettype none

interface frq_req_if import frq_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [KIND_BITS-1:0]      kind;
    logic [IO_HANDLE_BITS-1:0] handle;
    logic                      sent_flag;
    logic [TYPE_BITS-1:0]      entry_type;

    modport source (output valid, kind, handle, sent_flag, entry_type, input ready);
    modport sink   (input valid, kind, handle, sent_flag, entry_type, output ready);
endinterface

`default_nettype wire

FILE: rtl/frq_rsp_if.sv
// frq_rsp_if: result channel of the flagged request queue
// valid/ready handshake with status, found entry and empty flag
// depends on frq_pkg
`default_nettype none

interface frq_rsp_if import frq_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [STATUS_BITS-1:0]    status;
    logic [IO_HANDLE_BITS-1:0] out_handle;
    logic                      out_sent;
    logic [TYPE_BITS-1:0]      out_type;
    logic                      now_empty;

    modport source (output valid, status, out_handle, out_sent, out_type, now_empty,
                    input ready);
    modport sink   (input valid, status, out_handle, out_sent, out_type, now_empty,
                    output ready);
endinterface

`default_nettype wire

FILE: rtl/frq_cell.sv
// frq_cell: one queue slot, holds an entry and its registered match bit
// loads a new entry on enqueue or its upper neighbor on removal
// depends on frq_pkg
`default_nettype none

module frq_cell import frq_pkg::*; #(
    parameter int HANDLE_BITS = DEF_HANDLE_BITS,
    parameter int INDEX       = 0,
    parameter int CNT_BITS    = 5
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire t_cell_cmd              i_cmd,
    input  wire logic                   i_shift,
    input  wire logic [CNT_BITS-1:0]    i_occ,
    input  wire logic [HANDLE_BITS-1:0] i_new_handle,
    input  wire logic                   i_new_sent,
    input  wire logic [TYPE_BITS-1:0]   i_new_type,
    input  wire logic [HANDLE_BITS-1:0] i_nb_handle,
    input  wire logic                   i_nb_sent,
    input  wire logic [TYPE_BITS-1:0]   i_nb_type,
    output logic      [HANDLE_BITS-1:0] o_handle,
    output logic                        o_sent,
    output logic      [TYPE_BITS-1:0]   o_type,
    output logic                        o_match
);

    logic [HANDLE_BITS-1:0] r_handle;
    logic                   r_sent;
    logic [TYPE_BITS-1:0]   r_type;
    logic                   r_match;
    logic                   w_valid;
    logic                   w_tail;

    assign w_valid = (i_occ > CNT_BITS'(INDEX));
    assign w_tail  = (i_occ == CNT_BITS'(INDEX));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match <= 1'b0;
        end else if (i_cmd.capture) begin
            r_match <= w_valid & (i_cmd.match_any |
                       ((r_sent == i_cmd.sent) && (r_type == i_cmd.typ)));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.enq && w_tail) begin
            r_handle <= i_new_handle;
            r_sent   <= i_new_sent;
            r_type   <= i_new_type;
        end else if (i_shift) begin
            r_handle <= i_nb_handle;
            r_sent   <= i_nb_sent;
            r_type   <= i_nb_type;
        end
    end

    assign o_handle = r_handle;
    assign o_sent   = r_sent;
    assign o_type   = r_type;
    assign o_match  = r_match;

endmodule

`default_nettype wire

FILE: rtl/frq_prio.sv
// frq_prio: oldest-first priority over the row of cell match bits
// log-depth prefix or gives the first hit and the cells at or behind it
// no dependencies
`default_nettype none

module frq_prio #(
    parameter int N = 16
) (
    input  wire logic [N-1:0] i_match,
    output logic      [N-1:0] o_first,
    output logic      [N-1:0] o_incl,
    output logic              o_any
);

    localparam int LV = (N > 1) ? $clog2(N) : 1;

    logic [LV:0][N-1:0] w_pf;

    assign w_pf[0] = i_match;

    for (genvar l = 0; l < LV; l++) begin : g_lvl
        for (genvar i = 0; i < N; i++) begin : g_bit
            if (i >= (1 << l)) begin : g_or
                assign w_pf[l+1][i] = w_pf[l][i] | w_pf[l][i-(1<<l)];
            end else begin : g_pass
                assign w_pf[l+1][i] = w_pf[l][i];
            end
        end
    end

    assign o_incl  = w_pf[LV];
    assign o_first = w_pf[LV] & ~(w_pf[LV] << 1);
    assign o_any   = w_pf[LV][N-1];

endmodule

`default_nettype wire

FILE: rtl/flagged_request_queue.sv
// channel  dir  handshake         payload
// i_req    in   valid/ready       kind, handle, sent_flag, entry_type
// o_rsp    out  valid/ready       status, out_handle, out_sent, out_type, now_empty
//
// the accept edge of a request registers the match bit of every cell; once the result
// register is free, S_EXEC picks the oldest hit, writes the result and moves the cells
// one request is in work at a time; a new one is taken while a result waits to be read
// a result that finds the result register still full waits in place until it is read
// reset is synchronous and empties the queue at once, with no clearing pass
// depends on frq_pkg, frq_req_if, frq_rsp_if, frq_cell, frq_prio
`default_nettype none

module flagged_request_queue import frq_pkg::*; #(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int HANDLE_BITS = DEF_HANDLE_BITS
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    frq_req_if.sink   i_req,
    frq_rsp_if.source o_rsp
);

    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic {S_IDLE, S_EXEC} t_state;

    t_state                  r_state, n_state;
    logic [CNT_BITS-1:0]     r_occ, n_occ;
    t_kind                   r_kind;
    logic [HANDLE_BITS-1:0]  r_handle;
    logic                    r_sent;
    logic [TYPE_BITS-1:0]    r_type;
    logic                    r_out_valid, n_out_valid;
    t_status                 r_status, n_status;
    logic [IO_HANDLE_BITS-1:0] r_out_handle;
    logic                    r_out_sent, n_res_sent;
    logic [TYPE_BITS-1:0]    r_out_type, n_res_type;
    logic                    r_now_empty, n_now_empty;
    logic [HANDLE_BITS-1:0]  n_res_handle;
    logic [IO_HANDLE_BITS-1:0] w_res_ext;

    logic                    w_accept;
    logic                    w_done;
    logic                    w_take;
    logic                    w_enq;
    t_kind                   w_in_kind;
    logic [HANDLE_BITS-1:0]  w_in_handle;
    t_cell_cmd               w_cmd;

    logic [HANDLE_BITS-1:0]  c_handle [QUEUE_DEPTH];
    logic                    c_sent   [QUEUE_DEPTH];
    logic [TYPE_BITS-1:0]    c_type   [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0]  w_match;
    logic [QUEUE_DEPTH-1:0]  w_first;
    logic [QUEUE_DEPTH-1:0]  w_incl;
    logic [QUEUE_DEPTH-1:0]  w_shift;
    logic                    w_any;
    logic [HANDLE_BITS-1:0]  w_sel_handle;
    logic                    w_sel_sent;
    logic [TYPE_BITS-1:0]    w_sel_type;

    assign w_accept  = i_req.valid & i_req.ready;
    assign w_done    = (r_state == S_EXEC) & (~r_out_valid | o_rsp.ready);
    assign w_in_kind = t_kind'(i_req.kind);

    // keep the handle to the stored width
    for (genvar b = 0; b < HANDLE_BITS; b++) begin : g_hin
        if (b < IO_HANDLE_BITS) begin : g_bit
            assign w_in_handle[b] = i_req.handle[b];
        end else begin : g_zero
            assign w_in_handle[b] = 1'b0;
        end
    end

    for (genvar b = 0; b < IO_HANDLE_BITS; b++) begin : g_hout
        if (b < HANDLE_BITS) begin : g_bit
            assign w_res_ext[b] = n_res_handle[b];
        end else begin : g_zero
            assign w_res_ext[b] = 1'b0;
        end
    end

    // match pattern for the incoming request
    always_comb begin
        w_cmd           = '0;
        w_cmd.capture   = w_accept;
        w_cmd.enq       = w_enq;
        w_cmd.typ       = TYPE_REQ;
        case (w_in_kind)
            K_DEQUEUE, K_PEEK_HEAD: begin
                w_cmd.match_any = 1'b1;
            end
            K_PEEK_SENT, K_REMOVE_SENT: begin
                w_cmd.sent = 1'b1;
                w_cmd.typ  = TYPE_REQ;
            end
            K_REMOVE_DATA: begin
                w_cmd.sent = 1'b0;
                w_cmd.typ  = TYPE_RSP_DATA;
            end
            K_PEEK_UNSENT: begin
                w_cmd.sent = 1'b0;
                w_cmd.typ  = TYPE_REQ;
            end
            default: begin
                w_cmd.match_any = 1'b0;
            end
        endcase
    end

    for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
        logic [HANDLE_BITS-1:0] w_nb_handle;
        logic                   w_nb_sent;
        logic [TYPE_BITS-1:0]   w_nb_type;

        if (i + 1 < QUEUE_DEPTH) begin : g_nb
            assign w_nb_handle = c_handle[i+1];
            assign w_nb_sent   = c_sent[i+1];
            assign w_nb_type   = c_type[i+1];
        end else begin : g_end
            assign w_nb_handle = '0;
            assign w_nb_sent   = 1'b0;
            assign w_nb_type   = '0;
        end

        frq_cell #(
            .HANDLE_BITS (HANDLE_BITS),
            .INDEX       (i),
            .CNT_BITS    (CNT_BITS)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cmd        (w_cmd),
            .i_shift      (w_shift[i]),
            .i_occ        (r_occ),
            .i_new_handle (r_handle),
            .i_new_sent   (r_sent),
            .i_new_type   (r_type),
            .i_nb_handle  (w_nb_handle),
            .i_nb_sent    (w_nb_sent),
            .i_nb_type    (w_nb_type),
            .o_handle     (c_handle[i]),
            .o_sent       (c_sent[i]),
            .o_type       (c_type[i]),
            .o_match      (w_match[i])
        );
    end

    frq_prio #(
        .N (QUEUE_DEPTH)
    ) u_prio (
        .i_match (w_match),
        .o_first (w_first),
        .o_incl  (w_incl),
        .o_any   (w_any)
    );

    // select the oldest hit
    always_comb begin
        w_sel_handle = '0;
        w_sel_sent   = 1'b0;
        w_sel_type   = '0;
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            w_sel_handle = w_sel_handle | (c_handle[i] & {HANDLE_BITS{w_first[i]}});
            w_sel_sent   = w_sel_sent | (c_sent[i] & w_first[i]);
            w_sel_type   = w_sel_type | (c_type[i] & {TYPE_BITS{w_first[i]}});
        end
    end

    always_comb begin
        n_status     = ST_NONE;
        n_res_handle = '0;
        n_res_sent   = 1'b0;
        n_res_type   = '0;
        n_occ        = r_occ;
        w_enq        = 1'b0;
        w_take       = 1'b0;
        case (r_kind)
            K_ENQUEUE: begin
                if (r_occ == CNT_BITS'(QUEUE_DEPTH)) begin
                    n_status = ST_FULL;
                end else if (r_handle == '0) begin
                    n_status = ST_NULL;
                end else begin
                    n_status     = ST_OK;
                    n_res_handle = r_handle;
                    n_res_sent   = r_sent;
                    n_res_type   = r_type;
                    w_enq        = w_done;
                    n_occ        = r_occ + CNT_BITS'(1);
                end
            end
            K_CLEAR: begin
                n_status = ST_OK;
                n_occ    = '0;
            end
            default: begin
                if (w_any) begin
                    n_status     = ST_OK;
                    n_res_handle = w_sel_handle;
                    n_res_sent   = w_sel_sent;
                    n_res_type   = w_sel_type;
                    if (r_kind inside {K_DEQUEUE, K_REMOVE_SENT, K_REMOVE_DATA}) begin
                        w_take = w_done;
                        n_occ  = r_occ - CNT_BITS'(1);
                    end
                end
            end
        endcase
        n_now_empty = (n_occ == '0);
    end

    assign w_shift = w_incl & {QUEUE_DEPTH{w_take}};

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        if (o_rsp.valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_done) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_occ       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (w_done) begin
                r_occ        <= n_occ;
                r_status     <= n_status;
                r_out_handle <= w_res_ext;
                r_out_sent   <= n_res_sent;
                r_out_type   <= n_res_type;
                r_now_empty  <= n_now_empty;
            end
            if (w_accept) begin
                r_kind   <= w_in_kind;
                r_handle <= w_in_handle;
                r_sent   <= i_req.sent_flag;
                r_type   <= i_req.entry_type;
            end
        end
    end

    assign i_req.ready      = (r_state == S_IDLE);
    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.status     = r_status;
    assign o_rsp.out_handle = r_out_handle;
    assign o_rsp.out_sent   = r_out_sent;
    assign o_rsp.out_type   = r_out_type;
    assign o_rsp.now_empty  = r_now_empty;

`ifndef ASSERT_OFF
    a_occ_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= CNT_BITS'(QUEUE_DEPTH))
        else $error("occupancy beyond queue depth");

    a_first_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_first))
        else $error("more than one oldest hit");

    a_enq_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done && (r_kind == K_ENQUEUE) && (n_status == ST_OK)
        |=> r_occ == $past(r_occ) + CNT_BITS'(1))
        else $error("enqueue did not grow the queue");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_now_empty == (r_occ == '0)))
        else $error("empty flag disagrees with occupancy");
`endif

endmodule

`default_nettype wire
